FILE: design/bdd_pkg.sv
package bdd_pkg;

  localparam int NUM_CHANNELS = 8;
  localparam int MAX_ORDER    = 6;
  localparam int SAMPLE_BITS  = 24;

  // fixed field widths
  localparam int CH_W       = 3;
  localparam int ORD_W      = 3;
  localparam int SCALE_W    = 32;
  localparam int DERIV_W    = 32;
  localparam int FRAC_W     = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam int ROW_W  = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int TAP_W  = $clog2(MAX_ORDER + 1);
  localparam int COEF_W = 10;
  // sum of coefficient magnitudes is 1664 < 2^11
  localparam int MAG_W  = SAMPLE_BITS + 10;
  localparam int ACC_W  = MAG_W + 1;
  localparam int PROD_W = SAMPLE_BITS + COEF_W;
  localparam int PL_W   = MAG_W + FRAC_W;
  localparam int Q_W    = PL_W + 1;
  localparam int HIST_W = MAX_ORDER * SAMPLE_BITS;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t REG_DIFF_ORDER = cfg_idx_t'(0);
  localparam cfg_idx_t REG_RATE_SCALE = cfg_idx_t'(1);

  localparam logic [ORD_W-1:0]   DIFF_ORDER_RST = ORD_W'(1);
  localparam logic [SCALE_W-1:0] RATE_SCALE_RST = SCALE_W'(65536);

  // backward-difference weights times 60, newest sample first
  localparam int COEF_TABLE [6][7] = '{
    '{ 60,  -60,   0,    0,   0,   0,  0},
    '{ 90, -120,  30,    0,   0,   0,  0},
    '{110, -180,  90,  -20,   0,   0,  0},
    '{125, -240, 180,  -80,  15,   0,  0},
    '{137, -300, 300, -200,  75, -12,  0},
    '{147, -360, 450, -400, 225, -72, 10}
  };

  typedef struct packed {
    logic [CH_W-1:0]               channel;
    logic signed [SAMPLE_BITS-1:0] sample_value;
  } in_item_t;

  typedef struct packed {
    logic [CH_W-1:0]           channel_out;
    logic signed [DERIV_W-1:0] derivative;
    logic                      saturated;
  } out_item_t;

  typedef struct packed {
    logic load;
    logic mac;
    logic mag;
    logic mul;
    logic fin;
  } cmd_t;

  typedef struct packed {
    logic mac_last;
    logic out_busy;
  } sts_t;

  // order 0 acts as 1, anything above MAX_ORDER as MAX_ORDER
  function automatic logic [ORD_W-1:0] clamp_order(logic [ORD_W-1:0] ord);
    logic [ORD_W-1:0] res;
    res = ord;
    if (ord == '0) begin
      res = ORD_W'(1);
    end else if (int'(ord) > MAX_ORDER) begin
      res = ORD_W'(MAX_ORDER);
    end
    return res;
  endfunction

  function automatic logic signed [COEF_W-1:0] coef_of(logic [ORD_W-1:0] ord,
                                                       logic [2:0] tap);
    logic [2:0] ord_idx;
    ord_idx = ord - 3'd1;
    return COEF_W'(COEF_TABLE[ord_idx][tap]);
  endfunction

  // channel modulo NUM_CHANNELS on a 3-bit value
  function automatic logic [ROW_W-1:0] row_of(logic [CH_W-1:0] ch);
    logic [CH_W:0] v;
    v = {1'b0, ch};
    for (int i = 0; i < 8; i++) begin
      if (int'(v) >= NUM_CHANNELS) begin
        v = v - (CH_W+1)'(NUM_CHANNELS);
      end
    end
    return ROW_W'(v);
  endfunction

endpackage

FILE: design/bdd_ctrl.sv
module bdd_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  bdd_pkg::sts_t sts,
  output bdd_pkg::cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MAC,
    S_MAG,
    S_MUL,
    S_FIN
  } state_t;

  state_t state_r, state_nxt;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    cmd      = '0;
    cmd.load = (state_r == S_IDLE) && in_valid;
    cmd.mac  = (state_r == S_MAC);
    cmd.mag  = (state_r == S_MAG);
    cmd.mul  = (state_r == S_MUL);
    cmd.fin  = (state_r == S_FIN) && !sts.out_busy;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_valid) state_nxt = S_MAC;
      S_MAC:  if (sts.mac_last) state_nxt = S_MAG;
      S_MAG:  state_nxt = S_MUL;
      S_MUL:  state_nxt = S_FIN;
      S_FIN:  if (!sts.out_busy) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

FILE: design/bdd_dp.sv
module bdd_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  bdd_pkg::cmd_t                       cmd,
  output bdd_pkg::sts_t                       sts,
  input  bdd_pkg::in_item_t                   in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output bdd_pkg::out_item_t                  out_data,
  input  logic                                cfg_we,
  input  logic [bdd_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [bdd_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

  localparam int SB = bdd_pkg::SAMPLE_BITS;

  // configuration
  logic [bdd_pkg::ORD_W-1:0]   diff_order_r;
  logic [bdd_pkg::SCALE_W-1:0] rate_scale_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      diff_order_r <= bdd_pkg::DIFF_ORDER_RST;
      rate_scale_r <= bdd_pkg::RATE_SCALE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bdd_pkg::REG_DIFF_ORDER: diff_order_r <= cfg_wdata[bdd_pkg::ORD_W-1:0];
        bdd_pkg::REG_RATE_SCALE: rate_scale_r <= cfg_wdata[bdd_pkg::SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  // history memory: one row per channel, newest sample in the low slot
  logic [bdd_pkg::HIST_W-1:0]       hist_mem [bdd_pkg::NUM_CHANNELS];
  logic [bdd_pkg::NUM_CHANNELS-1:0] row_valid_r;
  logic [bdd_pkg::HIST_W-1:0]       mem_q_r;
  logic                             mem_q_valid_r;
  logic [bdd_pkg::ROW_W-1:0]        row_r;
  logic [bdd_pkg::ROW_W-1:0]        row_in;
  logic [bdd_pkg::CH_W-1:0]         ch_r;
  logic signed [SB-1:0]             x_r;

  logic [bdd_pkg::HIST_W-1:0] hist;
  logic [bdd_pkg::HIST_W-1:0] hist_shift;

  assign row_in = bdd_pkg::row_of(in_data.channel);
  assign hist   = mem_q_valid_r ? mem_q_r : '0;

  always_comb begin
    hist_shift[SB-1:0] = x_r;
    for (int i = 1; i < bdd_pkg::MAX_ORDER; i++) begin
      hist_shift[i*SB +: SB] = hist[(i-1)*SB +: SB];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mem_q_r <= hist_mem[row_in];
    end
    if (cmd.mag) begin
      hist_mem[row_r] <= hist_shift;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_valid_r <= '0;
    end else if (cmd.mag) begin
      row_valid_r[row_r] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mem_q_valid_r <= row_valid_r[row_in];
      row_r         <= row_in;
      ch_r          <= in_data.channel;
      x_r           <= in_data.sample_value;
    end
  end

  // multiply-accumulate, one tap per cycle
  logic [bdd_pkg::ORD_W-1:0]            ord;
  logic [bdd_pkg::TAP_W-1:0]            tap_r;
  logic signed [SB-1:0]                 tap_val;
  logic signed [bdd_pkg::COEF_W-1:0]    coef;
  logic signed [bdd_pkg::PROD_W-1:0]    prod;
  logic signed [bdd_pkg::ACC_W-1:0]     acc_r;

  assign ord  = bdd_pkg::clamp_order(diff_order_r);
  assign coef = bdd_pkg::coef_of(ord, 3'(tap_r));

  always_comb begin
    tap_val = x_r;
    for (int i = 0; i < bdd_pkg::MAX_ORDER; i++) begin
      if (int'(tap_r) == i + 1) begin
        tap_val = hist[i*SB +: SB];
      end
    end
  end

  assign prod = bdd_pkg::PROD_W'(coef) * bdd_pkg::PROD_W'(tap_val);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      tap_r <= '0;
      acc_r <= '0;
    end else if (cmd.mac) begin
      tap_r <= tap_r + bdd_pkg::TAP_W'(1);
      acc_r <= acc_r + bdd_pkg::ACC_W'(prod);
    end
  end

  // sign and magnitude, then scale in two 16-bit halves
  logic                          neg_r;
  logic [bdd_pkg::MAG_W-1:0]     mag_r;
  logic [bdd_pkg::PL_W-1:0]      plo_r;
  logic [bdd_pkg::PL_W-1:0]      phi_r;
  logic [bdd_pkg::PL_W-1:0]      plo_nxt;
  logic [bdd_pkg::PL_W-1:0]      phi_nxt;
  logic [bdd_pkg::FRAC_W-1:0]    scale_lo;
  logic [bdd_pkg::FRAC_W-1:0]    scale_hi;

  assign scale_lo = rate_scale_r[bdd_pkg::FRAC_W-1:0];
  assign scale_hi = rate_scale_r[bdd_pkg::SCALE_W-1:bdd_pkg::FRAC_W];
  assign plo_nxt  = bdd_pkg::PL_W'(mag_r) * bdd_pkg::PL_W'(scale_lo);
  assign phi_nxt  = bdd_pkg::PL_W'(mag_r) * bdd_pkg::PL_W'(scale_hi);

  always_ff @(posedge clk) begin
    if (cmd.mag) begin
      neg_r <= acc_r[bdd_pkg::ACC_W-1];
      mag_r <= acc_r[bdd_pkg::ACC_W-1] ? bdd_pkg::MAG_W'(-acc_r)
                                       : bdd_pkg::MAG_W'(acc_r);
    end
    if (cmd.mul) begin
      plo_r <= plo_nxt;
      phi_r <= phi_nxt;
    end
  end

  // combine, round toward minus infinity, saturate
  logic [bdd_pkg::Q_W-1:0]     q;
  logic                        round_up;
  logic                        sat;
  logic [bdd_pkg::DERIV_W-1:0] deriv;

  assign round_up = neg_r && (plo_r[bdd_pkg::FRAC_W-1:0] != '0);
  assign q = bdd_pkg::Q_W'(phi_r)
           + bdd_pkg::Q_W'(plo_r[bdd_pkg::PL_W-1:bdd_pkg::FRAC_W])
           + bdd_pkg::Q_W'(round_up);

  always_comb begin
    if (neg_r) begin
      sat   = (q[bdd_pkg::Q_W-1:bdd_pkg::DERIV_W] != '0) ||
              (q[bdd_pkg::DERIV_W-1] && (q[bdd_pkg::DERIV_W-2:0] != '0));
      deriv = sat ? {1'b1, {(bdd_pkg::DERIV_W-1){1'b0}}}
                  : -q[bdd_pkg::DERIV_W-1:0];
    end else begin
      sat   = (q[bdd_pkg::Q_W-1:bdd_pkg::DERIV_W-1] != '0);
      deriv = sat ? {1'b0, {(bdd_pkg::DERIV_W-1){1'b1}}}
                  : q[bdd_pkg::DERIV_W-1:0];
    end
  end

  // output register
  logic                 out_valid_r;
  bdd_pkg::out_item_t   out_data_r;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign sts       = '{mac_last: (int'(tap_r) == int'(ord)),
                       out_busy: out_valid_r && out_stall};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.fin) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fin) begin
      out_data_r.channel_out <= ch_r;
      out_data_r.derivative  <= deriv;
      out_data_r.saturated   <= sat;
    end
  end

endmodule

FILE: design/backward_difference_derivative.sv
// channel  direction  handshake            payload
// in_      input      in_valid / in_stall  bdd_pkg::in_item_t  (channel, sample_value)
// out_     output     out_valid/out_stall  bdd_pkg::out_item_t (channel_out, derivative,
//                                                               saturated)
// cfg_     input      cfg_we               cfg_index, cfg_wdata
//
// An item goes from accept to result register through these steps: the accept,
// with the history row read; order + 1 taps, one per step, through the single
// tap multiply-accumulate; then sign/magnitude, the two 16-bit scale products
// and the final add with saturation. One item is in flight at a time.
// Reset (rst_n low, synchronous) zeroes the history through per-channel valid
// bits and loads diff_order = 1, rate_scale = 65536.
// in_stall is high while an item is in flight; a result held under out_stall
// does not block the next accept, only the next result load.
module backward_difference_derivative (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  bdd_pkg::in_item_t              in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output bdd_pkg::out_item_t             out_data,
  input  logic                           cfg_we,
  input  logic [bdd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bdd_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  bdd_pkg::cmd_t cmd;
  bdd_pkg::sts_t sts;

  bdd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  bdd_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

endmodule
